### rtl/rgbyuy_pkg.sv
// Package for the RGB pixel pair to YUY2 converter.
// Holds register indexes, BT.601 Q8 coefficients and the luma/chroma functions.
// No dependencies.
package rgbyuy_pkg;

    localparam int PIXEL_W     = 32;
    localparam int COUNT_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OUT_FORMAT  = 2'd0,
        CFG_SRC_IS_RGBA = 2'd1
    } t_cfg_index;

    localparam logic [COUNT_W-1:0] COUNT_YUY2  = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_RGB32 = 2'd2;

    // Luma coefficients, unsigned Q8.
    localparam logic [7:0] LUMA_R      = 8'd66;
    localparam logic [7:0] LUMA_G      = 8'd129;
    localparam logic [7:0] LUMA_B      = 8'd25;
    localparam logic [7:0] LUMA_ROUND  = 8'd128;
    localparam logic [8:0] LUMA_OFFSET = 9'd16;

    // Chroma coefficients, signed Q9 on the pair sums.
    localparam logic signed [7:0] U_R = -8'sd38;
    localparam logic signed [7:0] U_G = -8'sd74;
    localparam logic signed [7:0] U_B = 8'sd112;
    localparam logic signed [7:0] V_R = 8'sd112;
    localparam logic signed [7:0] V_G = -8'sd94;
    localparam logic signed [7:0] V_B = -8'sd18;
    // Rounding half plus the 128 offset, pre-shifted by nine bits.
    localparam logic signed [18:0] CHROMA_BIAS = 19'sd65792;

    function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [16:0] acc;
        logic [8:0]  y;
        acc = 17'(LUMA_R) * 17'(r) + 17'(LUMA_G) * 17'(g) + 17'(LUMA_B) * 17'(b)
            + 17'(LUMA_ROUND);
        y = acc[16:8] + LUMA_OFFSET;
        if (y > 9'd255) begin
            return 8'hff;
        end
        return y[7:0];
    endfunction

    function automatic logic [7:0] chroma(input logic signed [7:0] cr,
                                          input logic signed [7:0] cg,
                                          input logic signed [7:0] cb,
                                          input logic [8:0] sr, input logic [8:0] sg,
                                          input logic [8:0] sb);
        logic signed [18:0] acc;
        logic signed [18:0] sh;
        acc = 19'(cr) * $signed(19'(sr)) + 19'(cg) * $signed(19'(sg))
            + 19'(cb) * $signed(19'(sb)) + CHROMA_BIAS;
        if (acc < 0) begin
            acc = '0;
        end
        sh = acc >>> 9;
        if (sh > 19'sd255) begin
            return 8'hff;
        end
        return sh[7:0];
    endfunction

endpackage

### rtl/rgb_pair_to_yuy2_converter.sv
// Top level of the RGB pixel pair to YUY2 / RGB32 converter.
// Depends on rgbyuy_pkg for coefficients, register indexes and conversion functions.
//
// Usage:
//   A pixel pair is requested by raising start with pixel_left and pixel_right on
//   i_pixel_left / i_pixel_right; the request is taken at a clock edge where start is
//   high and busy is low. busy is held low, so one pair can be taken every cycle.
//   The pair goes into an input register; the conversion runs between that register
//   and the result register. The result register loads at the edge after the request
//   edge; the result then sits on o_word_first, o_word_second and o_word_count
//   for one cycle with o_strobe high.
//   Throughput is one pair per cycle, set by the single register-to-register pass.
//   The receiver cannot stall: each result is taken at the edge ending its cycle.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; only
//   bit 0 of the data is kept, and indexes beyond the two registers are ignored.
//   o_cfg_ready is always high. Write registers only while no request is in flight.
//   Reset (i_rst_n low, synchronous) clears the pipeline valids and sets YUY2 output
//   with RGBA source order.
module rgb_pair_to_yuy2_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rgbyuy_pkg::PIXEL_W-1:0]      i_pixel_left,
    input  logic [rgbyuy_pkg::PIXEL_W-1:0]      i_pixel_right,
    output logic                                o_strobe,
    output logic [rgbyuy_pkg::PIXEL_W-1:0]      o_word_first,
    output logic [rgbyuy_pkg::PIXEL_W-1:0]      o_word_second,
    output logic [rgbyuy_pkg::COUNT_W-1:0]      o_word_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgbyuy_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rgbyuy_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                               r_out_format;
    logic                               r_src_is_rgba;
    logic                               r_in_valid;
    logic [rgbyuy_pkg::PIXEL_W-1:0]     r_left;
    logic [rgbyuy_pkg::PIXEL_W-1:0]     r_right;
    logic                               r_out_valid;
    logic [rgbyuy_pkg::PIXEL_W-1:0]     r_first;
    logic [rgbyuy_pkg::PIXEL_W-1:0]     r_second;
    logic [rgbyuy_pkg::COUNT_W-1:0]     r_count;

    logic [rgbyuy_pkg::PIXEL_W-1:0]     n_first;
    logic [rgbyuy_pkg::PIXEL_W-1:0]     n_second;
    logic [rgbyuy_pkg::COUNT_W-1:0]     n_count;

    logic [7:0] red_l, grn_l, blu_l, red_r, grn_r, blu_r;
    logic [8:0] sum_r, sum_g, sum_b;
    logic [7:0] y0, y1, u, v;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_format  <= 1'b0;
            r_src_is_rgba <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rgbyuy_pkg::CFG_OUT_FORMAT:  r_out_format  <= i_cfg_data[0];
                rgbyuy_pkg::CFG_SRC_IS_RGBA: r_src_is_rgba <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_left  <= i_pixel_left;
            r_right <= i_pixel_right;
        end
        if (r_in_valid) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_count  <= n_count;
        end
    end

    // Red and blue sit in byte 0 or byte 2 depending on the source order.
    always_comb begin
        grn_l = r_left[15:8];
        grn_r = r_right[15:8];
        if (r_src_is_rgba) begin
            red_l = r_left[7:0];
            blu_l = r_left[23:16];
            red_r = r_right[7:0];
            blu_r = r_right[23:16];
        end else begin
            red_l = r_left[23:16];
            blu_l = r_left[7:0];
            red_r = r_right[23:16];
            blu_r = r_right[7:0];
        end
        sum_r = 9'(red_l) + 9'(red_r);
        sum_g = 9'(grn_l) + 9'(grn_r);
        sum_b = 9'(blu_l) + 9'(blu_r);
        y0 = rgbyuy_pkg::luma(red_l, grn_l, blu_l);
        y1 = rgbyuy_pkg::luma(red_r, grn_r, blu_r);
        u  = rgbyuy_pkg::chroma(rgbyuy_pkg::U_R, rgbyuy_pkg::U_G, rgbyuy_pkg::U_B,
                                sum_r, sum_g, sum_b);
        v  = rgbyuy_pkg::chroma(rgbyuy_pkg::V_R, rgbyuy_pkg::V_G, rgbyuy_pkg::V_B,
                                sum_r, sum_g, sum_b);
    end

    always_comb begin
        if (r_out_format) begin
            if (r_src_is_rgba) begin
                n_first  = {r_left[31:24], r_left[7:0], r_left[15:8], r_left[23:16]};
                n_second = {r_right[31:24], r_right[7:0], r_right[15:8], r_right[23:16]};
            end else begin
                n_first  = r_left;
                n_second = r_right;
            end
            n_count = rgbyuy_pkg::COUNT_RGB32;
        end else begin
            n_first  = {v, y1, u, y0};
            n_second = '0;
            n_count  = rgbyuy_pkg::COUNT_YUY2;
        end
    end

    assign o_strobe      = r_out_valid;
    assign o_word_first  = r_first;
    assign o_word_second = r_second;
    assign o_word_count  = r_count;

`ifndef ASSERT_OFF
    a_strobe_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("request did not produce a result two cycles later");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_in_valid))
        else $error("result strobe without an accepted request");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_word_count == rgbyuy_pkg::COUNT_YUY2 ||
                      o_word_count == rgbyuy_pkg::COUNT_RGB32))
        else $error("word count out of range");

    a_yuy2_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word_count == rgbyuy_pkg::COUNT_YUY2) |-> (o_word_second == '0))
        else $error("second word not zero in YUY2 mode");

    a_reset_clears_strobe: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe high right after reset");
`endif

endmodule
